// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the swap cost block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_SAME(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("assertion failed");

`endif

// File: rtl/fssc_pkg.sv
// Package with the types, codes and constants of the swap cost block.
package fssc_pkg;

    localparam int DEF_MAX_FACILITIES = 64;
    localparam int DEF_MAX_CLIENTS    = 1024;
    localparam int DEF_MAX_SLOTS      = 16;

    localparam int COST_W = 42;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic [10:0] NUM_CLIENTS_RESET = 11'd1024;
    localparam logic [4:0]  NUM_SLOTS_RESET   = 5'd16;

    localparam logic CFG_NUM_CLIENTS = 1'b0;
    localparam logic CFG_NUM_SLOTS   = 1'b1;

    typedef enum logic [1:0] {
        CMD_WR_DIST = 2'd0,
        CMD_WR_SLOT = 2'd1,
        CMD_ASSIGN  = 2'd2,
        CMD_SWAP    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  facility;
        logic [9:0]  client;
        logic [3:0]  slot;
        logic [31:0] distance;
        logic        commit;
    } in_item_t;

    typedef struct packed {
        logic [41:0] total_cost;
        logic        cost_valid;
    } out_item_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [5:0]  facility;
        logic [9:0]  client;
        logic [3:0]  slot;
        logic [31:0] distance;
        logic        commit;
        logic        client_ok;
        logic        slot_ok;
    } q_item_t;

    typedef struct packed {
        logic [10:0] clients;
        logic [4:0]  slots;
    } cfg_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } back_status_t;

endpackage

// File: rtl/fssc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fssc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/fssc_front.sv
// Front end: configuration registers, item classification and a two-entry queue.
module fssc_front #(
    parameter int MAX_FACILITIES = 64,
    parameter int MAX_CLIENTS    = 1024,
    parameter int MAX_SLOTS      = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  fssc_pkg::in_item_t     item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [10:0]            cfg_data,
    input  fssc_pkg::back_status_t status,
    output logic                   head_valid,
    output fssc_pkg::q_item_t      head,
    output fssc_pkg::cfg_t         cfg
);
    import fssc_pkg::*;

    logic [10:0] nc_reg;
    logic [4:0]  ns_reg;
    q_item_t     q_reg [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [5:0]  fmod_tab [64];
    q_item_t     qin;
    logic        push;

    for (genvar i = 0; i < 64; i++)
    begin : g_fmod
        assign fmod_tab[i] = 6'(i % MAX_FACILITIES);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg <= NUM_CLIENTS_RESET;
            ns_reg <= NUM_SLOTS_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_NUM_CLIENTS)
            begin
                nc_reg <= cfg_data;
            end
            else
            begin
                ns_reg <= cfg_data[4:0];
            end
        end
    end

    always_comb
    begin
        cfg.clients = ({6'd0, nc_reg} > 17'(MAX_CLIENTS)) ? 11'(MAX_CLIENTS) : nc_reg;
        if (ns_reg == 5'd0)
        begin
            cfg.slots = 5'd1;
        end
        else if ({2'd0, ns_reg} > 7'(MAX_SLOTS))
        begin
            cfg.slots = 5'(MAX_SLOTS);
        end
        else
        begin
            cfg.slots = ns_reg;
        end
    end

    always_comb
    begin
        qin.cmd       = cmd_t'(item.command);
        qin.facility  = fmod_tab[item.facility];
        qin.client    = item.client;
        qin.slot      = item.slot;
        qin.distance  = item.distance;
        qin.commit    = item.commit;
        qin.client_ok = {7'd0, item.client} < 17'(MAX_CLIENTS);
        qin.slot_ok   = {3'd0, item.slot} < 7'(MAX_SLOTS);
    end

    assign item_stall = (cnt_reg == 2'd2) || status.clearing;
    assign push       = item_valid && !item_stall;
    assign head_valid = cnt_reg != 2'd0;
    assign head       = q_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !status.pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && status.pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (status.pop)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= qin;
        end
    end
endmodule

// File: rtl/fssc_back.sv
// Back end: sequencer that clears the serving store after reset and runs writes, full assignments and swap evaluations.
module fssc_back #(
    parameter int MAX_FACILITIES = 64,
    parameter int MAX_CLIENTS    = 1024,
    parameter int MAX_SLOTS      = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  fssc_pkg::q_item_t      head,
    input  fssc_pkg::cfg_t         cfg,
    output fssc_pkg::back_status_t status,
    output logic                   result_valid,
    input  logic                   result_stall,
    output fssc_pkg::out_item_t    result
);
    import fssc_pkg::*;

    localparam int FW  = $clog2(MAX_FACILITIES);
    localparam int CW  = MAX_CLIENTS > 1 ? $clog2(MAX_CLIENTS) : 1;
    localparam int SW  = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
    localparam int DD  = MAX_FACILITIES * MAX_CLIENTS;
    localparam int DAW = $clog2(DD);

    typedef enum logic [9:0] {
        ST_CLEAR   = 10'b0000000001,
        ST_IDLE    = 10'b0000000010,
        ST_MOD     = 10'b0000000100,
        ST_RD_SERV = 10'b0000001000,
        ST_RD_CUR  = 10'b0000010000,
        ST_RD_NEW  = 10'b0000100000,
        ST_DECIDE  = 10'b0001000000,
        ST_SCAN    = 10'b0010000000,
        ST_CLIENT  = 10'b0100000000,
        ST_FINISH  = 10'b1000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [10:0] j_reg, j_next;
    logic [3:0]  s_reg, s_next;
    logic [FW-1:0] removed_reg, removed_next;
    logic [FW-1:0] cur_reg, cur_next;
    logic [31:0] dcur_reg, dcur_next;
    logic [31:0] bd_reg, bd_next;
    logic [FW-1:0] bf_reg, bf_next;
    logic        first_reg, first_next;
    logic [4:0]  scan_reg, scan_next;
    logic        pend_reg, pend_next;
    logic [FW-1:0] pfac_reg, pfac_next;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic        rv_reg, rv_next;
    out_item_t   res_reg, res_next;
    logic [FW-1:0] slots_reg [MAX_SLOTS];

    logic          slot_we;
    logic [SW-1:0] slot_widx;
    logic [SW-1:0] slot_ridx;
    logic [FW-1:0] slot_rdata;
    logic [FW-1:0] trial_fac;
    logic [FW-1:0] fac;
    logic          is_swap;
    logic          dist_we;
    logic [DAW-1:0] dist_waddr;
    logic [DAW-1:0] dist_raddr;
    logic [31:0]   dist_rdata;
    logic          serv_we;
    logic [CW-1:0] serv_waddr;
    logic [FW-1:0] serv_wdata;
    logic [CW-1:0] serv_raddr;
    logic [FW-1:0] serv_rdata;
    logic [COST_W:0] sum;
    logic          pop;

    function automatic logic [DAW-1:0] daddr(input logic [FW-1:0] f, input logic [10:0] c);
        return DAW'(f) * DAW'(MAX_CLIENTS) + DAW'(c);
    endfunction

    fssc_ram #(.WIDTH(32), .DEPTH(DD)) u_dist (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (head.distance),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    fssc_ram #(.WIDTH(FW), .DEPTH(MAX_CLIENTS)) u_serv (
        .clk   (clk),
        .we    (serv_we),
        .waddr (serv_waddr),
        .wdata (serv_wdata),
        .raddr (serv_raddr),
        .rdata (serv_rdata)
    );

    assign fac        = FW'(head.facility);
    assign is_swap    = head.cmd == CMD_SWAP;
    assign slot_ridx  = (state_reg == ST_MOD) ? SW'(s_reg) : SW'(scan_reg);
    assign slot_rdata = slots_reg[slot_ridx];
    assign trial_fac  = (is_swap && ({1'b0, s_reg} == scan_reg)) ? fac : slot_rdata;
    assign dist_waddr = daddr(fac, {1'b0, head.client});
    assign sum        = {1'b0, cost_reg} + (COST_W + 1)'(bd_reg);

    assign status.clearing = state_reg == ST_CLEAR;
    assign status.pop      = pop;
    assign result_valid    = rv_reg;
    assign result          = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        j_next       = j_reg;
        s_next       = s_reg;
        removed_next = removed_reg;
        cur_next     = cur_reg;
        dcur_next    = dcur_reg;
        bd_next      = bd_reg;
        bf_next      = bf_reg;
        first_next   = first_reg;
        scan_next    = scan_reg;
        pend_next    = pend_reg;
        pfac_next    = pfac_reg;
        cost_next    = cost_reg;
        rv_next      = rv_reg && result_stall;
        res_next     = res_reg;
        slot_we      = 1'b0;
        slot_widx    = SW'(head.slot);
        dist_we      = 1'b0;
        dist_raddr   = daddr(fac, j_reg);
        serv_we      = 1'b0;
        serv_waddr   = CW'(j_reg);
        serv_wdata   = bf_reg;
        serv_raddr   = CW'(j_reg);
        pop          = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                serv_we    = 1'b1;
                serv_waddr = clr_reg;
                serv_wdata = '0;
                clr_next   = clr_reg + CW'(1);
                if (clr_reg == CW'(MAX_CLIENTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cost_next = '0;
                j_next    = '0;
                s_next    = head.slot;
                scan_next = '0;
                pend_next = 1'b0;
                first_next = 1'b1;
                if (head_valid)
                begin
                    unique case (head.cmd)
                        CMD_WR_DIST:
                        begin
                            dist_we    = head.client_ok;
                            state_next = ST_FINISH;
                        end
                        CMD_WR_SLOT:
                        begin
                            slot_we    = head.slot_ok;
                            state_next = ST_FINISH;
                        end
                        CMD_ASSIGN:
                        begin
                            state_next = (cfg.clients == 11'd0) ? ST_FINISH : ST_SCAN;
                        end
                        CMD_SWAP:
                        begin
                            state_next = ST_MOD;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                if ({1'b0, s_reg} >= cfg.slots)
                begin
                    s_next = s_reg - cfg.slots[3:0];
                end
                else
                begin
                    removed_next = slot_rdata;
                    state_next   = (cfg.clients == 11'd0) ? ST_FINISH : ST_RD_SERV;
                end
            end
            ST_RD_SERV:
            begin
                state_next = ST_RD_CUR;
            end
            ST_RD_CUR:
            begin
                cur_next   = serv_rdata;
                dist_raddr = daddr(serv_rdata, j_reg);
                state_next = ST_RD_NEW;
            end
            ST_RD_NEW:
            begin
                dcur_next  = dist_rdata;
                dist_raddr = daddr(fac, j_reg);
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                scan_next  = '0;
                pend_next  = 1'b0;
                first_next = 1'b1;
                if (dcur_reg >= dist_rdata)
                begin
                    bd_next    = dist_rdata;
                    bf_next    = fac;
                    state_next = ST_CLIENT;
                end
                else if (cur_reg == removed_reg)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    bd_next    = dcur_reg;
                    bf_next    = cur_reg;
                    state_next = ST_CLIENT;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && (first_reg || (dist_rdata < bd_reg)))
                begin
                    bd_next    = dist_rdata;
                    bf_next    = pfac_reg;
                    first_next = 1'b0;
                end
                if (scan_reg < cfg.slots)
                begin
                    dist_raddr = daddr(trial_fac, j_reg);
                    pfac_next  = trial_fac;
                    pend_next  = 1'b1;
                    scan_next  = scan_reg + 5'd1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_CLIENT;
                end
            end
            ST_CLIENT:
            begin
                cost_next  = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
                serv_we    = !is_swap || head.commit;
                j_next     = j_reg + 11'd1;
                scan_next  = '0;
                pend_next  = 1'b0;
                first_next = 1'b1;
                if (j_reg + 11'd1 == cfg.clients)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = is_swap ? ST_RD_SERV : ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (!rv_reg || !result_stall)
                begin
                    rv_next             = 1'b1;
                    res_next.total_cost = cost_reg;
                    res_next.cost_valid = (head.cmd == CMD_ASSIGN) || is_swap;
                    pop                 = 1'b1;
                    slot_we             = is_swap && head.commit;
                    slot_widx           = SW'(s_reg);
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            j_reg     <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            first_reg <= 1'b1;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            j_reg     <= j_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            first_reg <= first_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg       <= s_next;
        removed_reg <= removed_next;
        cur_reg     <= cur_next;
        dcur_reg    <= dcur_next;
        bd_reg      <= bd_next;
        bf_reg      <= bf_next;
        pfac_reg    <= pfac_next;
        cost_reg    <= cost_next;
        res_reg     <= res_next;
        if (slot_we)
        begin
            slots_reg[slot_widx] <= fac;
        end
    end
endmodule

// File: rtl/facility_swap_service_cost_core.sv
// Top level of the facility swap service cost block.
// Items arrive on item/item_valid/item_stall and are taken when valid is high
// and stall is low. Each item gives exactly one result on result/result_valid,
// held until a cycle with result_stall low. Registers num_clients (index 0)
// and num_slots (index 1) are written on the cfg channel, which is always ready.
// A distance or slot write goes straight to the finish state, which registers its
// result. A full assignment scans the S active slots for each of the C active
// clients over the distance memory read port. A swap evaluation reads, for each
// client, its serving facility and the distances to it and to the new facility,
// and scans the active slots for each client of the removed facility that the
// new facility does not take; the slot number is first folded into the active slots.
// After reset the serving store is cleared, one client per cycle, over all
// MAX_CLIENTS entries while item_stall stays high; distances and slots are
// undefined until written. A two-entry queue keeps accepting items while the
// sequencer works, until both entries are full; when the receiver stalls, the result
// register holds and the sequencer waits before it retires the next item.
`include "assert_macros.svh"
module facility_swap_service_cost_core #(
    parameter int MAX_FACILITIES = fssc_pkg::DEF_MAX_FACILITIES,
    parameter int MAX_CLIENTS    = fssc_pkg::DEF_MAX_CLIENTS,
    parameter int MAX_SLOTS      = fssc_pkg::DEF_MAX_SLOTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  fssc_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output fssc_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [10:0]         cfg_data
);
    import fssc_pkg::*;

    logic         head_valid;
    q_item_t      head;
    cfg_t         cfg;
    back_status_t status;

    fssc_front #(
        .MAX_FACILITIES (MAX_FACILITIES),
        .MAX_CLIENTS    (MAX_CLIENTS),
        .MAX_SLOTS      (MAX_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (status),
        .head_valid (head_valid),
        .head       (head),
        .cfg        (cfg)
    );

    fssc_back #(
        .MAX_FACILITIES (MAX_FACILITIES),
        .MAX_CLIENTS    (MAX_CLIENTS),
        .MAX_SLOTS      (MAX_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .cfg          (cfg),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `ASSERT_SAME(a_clear_stalls, clk, rst_n, status.clearing, item_stall)
    `ASSERT_SAME(a_pop_needs_head, clk, rst_n, status.pop, head_valid)
    `ASSERT_NEXT(a_push_fills, clk, rst_n, item_valid && !item_stall, head_valid)
    `ASSERT_NEXT(a_pop_shows, clk, rst_n, status.pop, result_valid)
endmodule
